FILE: rtl/wpbd_pkg.sv
// Shared constants, types and register indexes of the waveform peak bar decimator.
package wpbd_pkg;

   // Field and register widths.
   localparam int SAMPLE_W = 16;
   localparam int COUNT_W  = 20;
   localparam int WIDTH_W  = 13;
   localparam int HEIGHT_W = 5;

   // Display geometry. MAX_BARS must be a power of two: the column steps use a shift and a mask.
   localparam int MAX_BARS     = 2048;
   localparam int IMAGE_HEIGHT = 40;
   localparam int HALF_SCALE   = IMAGE_HEIGHT / 2 - 2;

   // A bar number needs BAR_W bits, the bar count itself one more.
   localparam int BAR_W  = $clog2(MAX_BARS);
   localparam int BARS_W = BAR_W + 1;

   // A magnitude runs up to 2**(SAMPLE_W-1), which needs one bit more than a sample.
   localparam int MAG_W   = SAMPLE_W + 1;
   localparam int SCALE_W = $clog2(HALF_SCALE + 1);
   localparam int PROD_W  = MAG_W + SCALE_W;

   // Divider step counter.
   localparam int DIV_CNT_W = $clog2(COUNT_W + 1);

   // Queue between the front and the back end.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Configuration port.
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = COUNT_W;
   localparam logic [CSR_INDEX_W-1:0] CSR_SAMPLE_COUNT = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FULL_WIDTH   = 1'b1;

   // Register values after reset and the traversal steps that follow from them.
   localparam int RESET_SAMPLE_COUNT = 2048;
   localparam int RESET_FULL_WIDTH   = 2048;
   localparam int RESET_BARS  = (RESET_FULL_WIDTH < MAX_BARS) ? RESET_FULL_WIDTH : MAX_BARS;
   localparam int RESET_N_EFF = (RESET_SAMPLE_COUNT < RESET_BARS) ? RESET_BARS
                                                                 : RESET_SAMPLE_COUNT;
   localparam int RESET_SAMPLE_STEP = RESET_N_EFF / RESET_BARS;
   localparam int RESET_SAMPLE_REM  = RESET_N_EFF % RESET_BARS;
   localparam int RESET_COLUMN_STEP = RESET_FULL_WIDTH / RESET_BARS;
   localparam int RESET_COLUMN_REM  = RESET_FULL_WIDTH % RESET_BARS;

   // A finished bar as the front hands it to the back end.
   typedef struct packed {
      logic [BAR_W-1:0]   bar_index;
      logic [WIDTH_W-1:0] x_start;
      logic [WIDTH_W-1:0] x_end;
      logic [MAG_W-1:0]   peak;
      logic               last_bar;
   } bar_desc_type;

   // Request to the step divider.
   typedef struct packed {
      logic               start;
      logic [COUNT_W-1:0] dividend;
      logic [BARS_W-1:0]  divisor;
   } div_req_type;

   // Result and status of the step divider.
   typedef struct packed {
      logic               busy;
      logic               done;
      logic [COUNT_W-1:0] quotient;
      logic [BAR_W-1:0]   remainder;
   } div_rsp_type;

   // Fill status of the bar queue.
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

FILE: rtl/wpbd_divider.sv
// Restoring divider, one quotient bit a cycle, for the samples-per-bar step.
module wpbd_divider (
   input  logic                clock,
   input  logic                reset,
   input  wpbd_pkg::div_req_type div_req,
   output wpbd_pkg::div_rsp_type div_rsp
);
   import wpbd_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] count_ff, count_in;
   logic [COUNT_W-1:0]   quot_ff, quot_in;
   logic [BAR_W-1:0]     rem_ff, rem_in;
   logic [BARS_W-1:0]    divisor_ff, divisor_in;
   logic [BARS_W-1:0]    shifted;
   logic [BARS_W-1:0]    diff;

   // One restoring step: shift the next dividend bit into the partial remainder.
   always_comb begin
      shifted = {rem_ff, quot_ff[COUNT_W-1]};
      diff    = shifted - divisor_ff;
      busy_in    = busy_ff;
      done_in    = 1'b0;
      count_in   = count_ff;
      quot_in    = quot_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      if (div_req.start) begin
         // A new request overrides one still running.
         busy_in    = 1'b1;
         count_in   = DIV_CNT_W'(COUNT_W);
         quot_in    = div_req.dividend;
         rem_in     = '0;
         divisor_in = div_req.divisor;
      end else if (busy_ff) begin
         if (shifted >= divisor_ff) begin
            rem_in  = diff[BAR_W-1:0];
            quot_in = {quot_ff[COUNT_W-2:0], 1'b1};
         end else begin
            rem_in  = shifted[BAR_W-1:0];
            quot_in = {quot_ff[COUNT_W-2:0], 1'b0};
         end
         count_in = count_ff - DIV_CNT_W'(1);
         if (count_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      quot_ff    <= quot_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign div_rsp.busy      = busy_ff;
   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quot_ff;
   assign div_rsp.remainder = rem_ff;

endmodule

FILE: rtl/wpbd_front.sv
// Front end: configuration registers, sample intake, peak tracking and bar boundaries.
module wpbd_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [wpbd_pkg::SAMPLE_W-1:0]  req_sample,
   input  logic                                  csr_we,
   input  logic [wpbd_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [wpbd_pkg::CSR_DATA_W-1:0]       csr_wdata,
   output wpbd_pkg::div_req_type                 div_req,
   input  wpbd_pkg::div_rsp_type                 div_rsp,
   output logic                                  push,
   output wpbd_pkg::bar_desc_type                push_data,
   input  wpbd_pkg::queue_status_type            queue_status
);
   import wpbd_pkg::*;

   // Configuration.
   logic [COUNT_W-1:0] samples_cfg_ff, samples_cfg_in;
   logic [WIDTH_W-1:0] width_cfg_ff, width_cfg_in;
   logic               pending_ff, pending_in;

   // Samples-per-bar step from the divider.
   logic [COUNT_W-1:0] sample_step_ff, sample_step_in;
   logic [BAR_W-1:0]   sample_rem_ff, sample_rem_in;

   // Traversal state.
   logic [COUNT_W-1:0] seen_ff, seen_in;
   logic [BAR_W-1:0]   bar_ff, bar_in;
   logic [MAG_W-1:0]   peak_ff, peak_in;
   logic [COUNT_W-1:0] sample_bound_ff, sample_bound_in;
   logic [BAR_W-1:0]   sample_acc_ff, sample_acc_in;
   logic [WIDTH_W-1:0] column_bound_ff, column_bound_in;
   logic [BAR_W-1:0]   column_acc_ff, column_acc_in;
   logic [WIDTH_W-1:0] column_start_ff, column_start_in;

   logic [WIDTH_W-1:0] width_eff;
   logic [BARS_W-1:0]  bars;
   logic [WIDTH_W-1:0] column_step;
   logic [BAR_W-1:0]   column_rem;
   logic [COUNT_W-1:0] samples_eff;
   logic               accept;
   logic [MAG_W-1:0]   sample_ext;
   logic [MAG_W-1:0]   mag;
   logic [MAG_W-1:0]   peak_new;
   logic [COUNT_W-1:0] seen_next;
   logic               hit;
   logic               last;
   logic [BARS_W-1:0]  sample_acc_sum;
   logic [BARS_W-1:0]  column_acc_sum;

   // Bar count and column steps follow from the width directly.
   always_comb begin
      width_eff = (width_cfg_ff == '0) ? WIDTH_W'(1) : width_cfg_ff;
      if (width_eff >= WIDTH_W'(MAX_BARS)) begin
         bars        = BARS_W'(MAX_BARS);
         column_step = width_eff >> BAR_W;
         column_rem  = width_eff[BAR_W-1:0];
      end else begin
         bars        = width_eff[BARS_W-1:0];
         column_step = WIDTH_W'(1);
         column_rem  = '0;
      end
      samples_eff = (samples_cfg_ff < COUNT_W'(bars)) ? COUNT_W'(bars) : samples_cfg_ff;
   end

   // The divider is started the cycle after a register write.
   assign div_req.start    = pending_ff;
   assign div_req.dividend = samples_eff;
   assign div_req.divisor  = bars;

   assign req_ready = !pending_ff && !div_rsp.busy && !div_rsp.done && !queue_status.full;
   assign accept    = req_valid && req_ready;

   // Magnitude of the sample and the peak it leaves.
   always_comb begin
      sample_ext = MAG_W'(req_sample);
      mag        = sample_ext[MAG_W-1] ? (MAG_W'(0) - sample_ext) : sample_ext;
      peak_new   = (mag > peak_ff) ? mag : peak_ff;
      seen_next  = seen_ff + COUNT_W'(1);
      hit        = (seen_next == sample_bound_ff);
      last       = (BARS_W'(bar_ff) + BARS_W'(1) >= bars);
      sample_acc_sum = BARS_W'(sample_acc_ff) + BARS_W'(sample_rem_ff);
      column_acc_sum = BARS_W'(column_acc_ff) + BARS_W'(column_rem);
   end

   // Bar descriptor for the queue.
   assign push                = accept && hit;
   assign push_data.bar_index = bar_ff;
   assign push_data.x_start   = column_start_ff;
   assign push_data.x_end     = column_bound_ff;
   assign push_data.peak      = peak_new;
   assign push_data.last_bar  = last;

   // Next state of configuration and traversal.
   always_comb begin
      samples_cfg_in  = samples_cfg_ff;
      width_cfg_in    = width_cfg_ff;
      pending_in      = 1'b0;
      sample_step_in  = sample_step_ff;
      sample_rem_in   = sample_rem_ff;
      seen_in         = seen_ff;
      bar_in          = bar_ff;
      peak_in         = peak_ff;
      sample_bound_in = sample_bound_ff;
      sample_acc_in   = sample_acc_ff;
      column_bound_in = column_bound_ff;
      column_acc_in   = column_acc_ff;
      column_start_in = column_start_ff;

      if (csr_we) begin
         pending_in = 1'b1;
         case (csr_index)
            CSR_SAMPLE_COUNT: samples_cfg_in = csr_wdata[COUNT_W-1:0];
            CSR_FULL_WIDTH:   width_cfg_in   = csr_wdata[WIDTH_W-1:0];
            default: ;
         endcase
      end

      if (div_rsp.done) begin
         // New steps arrive: restart the clip from bar zero.
         sample_step_in  = div_rsp.quotient;
         sample_rem_in   = div_rsp.remainder;
         seen_in         = '0;
         bar_in          = '0;
         peak_in         = '0;
         sample_bound_in = div_rsp.quotient;
         sample_acc_in   = div_rsp.remainder;
         column_bound_in = column_step;
         column_acc_in   = column_rem;
         column_start_in = '0;
      end else if (accept) begin
         peak_in = peak_new;
         seen_in = seen_next;
         if (hit && last) begin
            // End of clip: traversal goes back to its starting values.
            seen_in         = '0;
            bar_in          = '0;
            peak_in         = '0;
            sample_bound_in = sample_step_ff;
            sample_acc_in   = sample_rem_ff;
            column_bound_in = column_step;
            column_acc_in   = column_rem;
            column_start_in = '0;
         end else if (hit) begin
            bar_in  = bar_ff + BAR_W'(1);
            peak_in = '0;
            if (sample_acc_sum >= bars) begin
               sample_acc_in   = BAR_W'(sample_acc_sum - bars);
               sample_bound_in = sample_bound_ff + sample_step_ff + COUNT_W'(1);
            end else begin
               sample_acc_in   = sample_acc_sum[BAR_W-1:0];
               sample_bound_in = sample_bound_ff + sample_step_ff;
            end
            column_start_in = column_bound_ff;
            if (column_acc_sum >= bars) begin
               column_acc_in   = BAR_W'(column_acc_sum - bars);
               column_bound_in = column_bound_ff + column_step + WIDTH_W'(1);
            end else begin
               column_acc_in   = column_acc_sum[BAR_W-1:0];
               column_bound_in = column_bound_ff + column_step;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         samples_cfg_ff  <= COUNT_W'(RESET_SAMPLE_COUNT);
         width_cfg_ff    <= WIDTH_W'(RESET_FULL_WIDTH);
         pending_ff      <= 1'b0;
         sample_step_ff  <= COUNT_W'(RESET_SAMPLE_STEP);
         sample_rem_ff   <= BAR_W'(RESET_SAMPLE_REM);
         seen_ff         <= '0;
         bar_ff          <= '0;
         peak_ff         <= '0;
         sample_bound_ff <= COUNT_W'(RESET_SAMPLE_STEP);
         sample_acc_ff   <= BAR_W'(RESET_SAMPLE_REM);
         column_bound_ff <= WIDTH_W'(RESET_COLUMN_STEP);
         column_acc_ff   <= BAR_W'(RESET_COLUMN_REM);
         column_start_ff <= '0;
      end else begin
         samples_cfg_ff  <= samples_cfg_in;
         width_cfg_ff    <= width_cfg_in;
         pending_ff      <= pending_in;
         sample_step_ff  <= sample_step_in;
         sample_rem_ff   <= sample_rem_in;
         seen_ff         <= seen_in;
         bar_ff          <= bar_in;
         peak_ff         <= peak_in;
         sample_bound_ff <= sample_bound_in;
         sample_acc_ff   <= sample_acc_in;
         column_bound_ff <= column_bound_in;
         column_acc_ff   <= column_acc_in;
         column_start_ff <= column_start_in;
      end
   end

endmodule

FILE: rtl/wpbd_queue.sv
// Short queue of finished bar descriptors between the front and the back end.
module wpbd_queue (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   input  wpbd_pkg::bar_desc_type         push_data,
   input  logic                           pop,
   output wpbd_pkg::bar_desc_type         head_data,
   output wpbd_pkg::queue_status_type     queue_status
);
   import wpbd_pkg::*;

   bar_desc_type      entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign queue_status.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign queue_status.empty = (count_ff == '0);
   assign do_push = push && !queue_status.full;
   assign do_pop  = pop && !queue_status.empty;
   assign head_data = entry_ff[rd_ptr_ff];

   // Pointer and fill count update; pointers wrap at the queue depth.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: rtl/wpbd_back.sv
// Back end: height scaling and the registered result stage.
module wpbd_back (
   input  logic                               clock,
   input  logic                               reset,
   input  wpbd_pkg::bar_desc_type             head_data,
   input  wpbd_pkg::queue_status_type         queue_status,
   output logic                               pop,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [wpbd_pkg::BAR_W-1:0]         rsp_bar_index,
   output logic [wpbd_pkg::WIDTH_W-1:0]       rsp_x_start,
   output logic [wpbd_pkg::WIDTH_W-1:0]       rsp_x_end,
   output logic [wpbd_pkg::HEIGHT_W-1:0]      rsp_bar_height,
   output logic                               rsp_last_bar
);
   import wpbd_pkg::*;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [BAR_W-1:0]    bar_index_ff;
   logic [WIDTH_W-1:0]  x_start_ff;
   logic [WIDTH_W-1:0]  x_end_ff;
   logic [HEIGHT_W-1:0] height_ff;
   logic                last_bar_ff;
   logic [PROD_W-1:0]   prod;
   logic [PROD_W-1:0]   height_raw;
   logic [HEIGHT_W-1:0] height;

   // Scale the peak to a half height, never below one pixel.
   always_comb begin
      prod       = PROD_W'(head_data.peak) * PROD_W'(HALF_SCALE);
      height_raw = prod >> (SAMPLE_W - 1);
      height     = (height_raw == '0) ? HEIGHT_W'(1) : height_raw[HEIGHT_W-1:0];
   end

   // Take the next bar whenever the result stage is empty or being emptied.
   assign pop = !queue_status.empty && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (pop) begin
         bar_index_ff <= head_data.bar_index;
         x_start_ff   <= head_data.x_start;
         x_end_ff     <= head_data.x_end;
         height_ff    <= height;
         last_bar_ff  <= head_data.last_bar;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_bar_index  = bar_index_ff;
   assign rsp_x_start    = x_start_ff;
   assign rsp_x_end      = x_end_ff;
   assign rsp_bar_height = height_ff;
   assign rsp_last_bar   = last_bar_ff;

endmodule

FILE: rtl/waveform_peak_bar_decimator_unit.sv
// Top level of the waveform peak bar decimator.
//
//   channel  direction  handshake              payload
//   req      in         req_valid/req_ready    req_sample
//   rsp      out        rsp_valid/rsp_ready    rsp_bar_index, rsp_x_start, rsp_x_end,
//                                              rsp_bar_height, rsp_last_bar
//   csr      in         csr_we                 csr_index, csr_wdata
//
// One sample is taken every cycle while req_ready is high; a bar result leaves through the
// bar queue and the registered result stage. After a register write req_ready stays low while
// the serial divider works out the samples per bar, one quotient bit a cycle.
// Reset is synchronous and loads the default clip geometry; no clearing pass is needed.
// A stalled result side fills the four-entry bar queue before req_ready drops.
module waveform_peak_bar_decimator_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [wpbd_pkg::SAMPLE_W-1:0]  req_sample,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [wpbd_pkg::BAR_W-1:0]            rsp_bar_index,
   output logic [wpbd_pkg::WIDTH_W-1:0]          rsp_x_start,
   output logic [wpbd_pkg::WIDTH_W-1:0]          rsp_x_end,
   output logic [wpbd_pkg::HEIGHT_W-1:0]         rsp_bar_height,
   output logic                                  rsp_last_bar,
   input  logic                                  csr_we,
   input  logic [wpbd_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [wpbd_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import wpbd_pkg::*;

   div_req_type      div_req;
   div_rsp_type      div_rsp;
   logic             push;
   bar_desc_type     push_data;
   logic             pop;
   bar_desc_type     head_data;
   queue_status_type queue_status;

   // Serial divider for the samples-per-bar step.
   wpbd_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // Intake, peak tracking and boundary accumulators.
   wpbd_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_sample   (req_sample),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .div_req      (div_req),
      .div_rsp      (div_rsp),
      .push         (push),
      .push_data    (push_data),
      .queue_status (queue_status)
   );

   // Finished bars waiting for the back end.
   wpbd_queue u_queue (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .push_data    (push_data),
      .pop          (pop),
      .head_data    (head_data),
      .queue_status (queue_status)
   );

   // Height scaling and result register.
   wpbd_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_data      (head_data),
      .queue_status   (queue_status),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_bar_index  (rsp_bar_index),
      .rsp_x_start    (rsp_x_start),
      .rsp_x_end      (rsp_x_end),
      .rsp_bar_height (rsp_bar_height),
      .rsp_last_bar   (rsp_last_bar)
   );

endmodule

FILE: rtl/wpbd_checker.sv
// Port-level checks of the waveform peak bar decimator and their binding to the top level.
module wpbd_checker (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_ready,
   input  logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   input  logic [wpbd_pkg::BAR_W-1:0]            rsp_bar_index,
   input  logic [wpbd_pkg::WIDTH_W-1:0]          rsp_x_start,
   input  logic [wpbd_pkg::WIDTH_W-1:0]          rsp_x_end,
   input  logic [wpbd_pkg::HEIGHT_W-1:0]         rsp_bar_height,
   input  logic                                  rsp_last_bar,
   input  logic                                  csr_we
);
   import wpbd_pkg::*;

   // A result that is not taken holds its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_bar_index) && $stable(rsp_x_start)
         && $stable(rsp_x_end) && $stable(rsp_bar_height) && $stable(rsp_last_bar))
      else $error("result changed while stalled");

   // Every bar spans at least one pixel column.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_x_end > rsp_x_start)
      else $error("bar with an empty column span");

   // A bar is never drawn with zero height.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_bar_height != '0)
      else $error("bar height of zero");

   // A register write holds off samples while the new steps are worked out.
   assert property (@(posedge clock) disable iff (reset)
      csr_we |=> !req_ready)
      else $error("sample intake open right after a register write");

endmodule

bind waveform_peak_bar_decimator_unit wpbd_checker u_wpbd_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_bar_index  (rsp_bar_index),
   .rsp_x_start    (rsp_x_start),
   .rsp_x_end      (rsp_x_end),
   .rsp_bar_height (rsp_bar_height),
   .rsp_last_bar   (rsp_last_bar),
   .csr_we         (csr_we)
);

FILE: bench/waveform_peak_bar_decimator_unit_tb.sv
// Self-checking testbench for the waveform peak bar decimator: directed table, a backed-up stretch, then random clips.
`timescale 1ns / 1ps

module waveform_peak_bar_decimator_unit_tb;
   import wpbd_pkg::*;

   // Half height of a full-scale bar and the bench timing knobs.
   localparam int BAR_HALF_RANGE = IMAGE_HEIGHT / 2 - 2;
   localparam int IDLE_PERCENT   = 36;
   localparam int IDLE_PAUSE     = COUNT_W + 8;
   localparam int HOLD_CYCLES    = 300;
   localparam int RANDOM_ITEMS   = 1880;
   localparam int CYCLE_LIMIT    = 400000;
   localparam int REPORT_LIMIT   = 10;
   localparam int DIRECTED_ROWS  = 27;

   // One finished bar as it leaves the block.
   typedef struct packed {
      logic [BAR_W-1:0]    bar_index;
      logic [WIDTH_W-1:0]  x_start;
      logic [WIDTH_W-1:0]  x_end;
      logic [HEIGHT_W-1:0] bar_height;
      logic                last_bar;
   } bar_result_type;

   typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_type;

   // A row of the directed table: either a sample or a register write.
   typedef struct {
      row_kind_type             reg_kind;
      logic [CSR_INDEX_W-1:0]   reg_index;
      logic [CSR_DATA_W-1:0]    reg_data;
      logic signed [SAMPLE_W-1:0] sample;
      bit                       typed;
      bar_result_type           bar;
   } stim_row_type;

   logic                        clock;
   logic                        reset;
   logic                        req_valid;
   logic                        req_ready;
   logic signed [SAMPLE_W-1:0]  req_sample;
   logic                        rsp_valid;
   logic                        rsp_ready;
   logic [BAR_W-1:0]            rsp_bar_index;
   logic [WIDTH_W-1:0]          rsp_x_start;
   logic [WIDTH_W-1:0]          rsp_x_end;
   logic [HEIGHT_W-1:0]         rsp_bar_height;
   logic                        rsp_last_bar;
   logic                        csr_we;
   logic [CSR_INDEX_W-1:0]      csr_index;
   logic [CSR_DATA_W-1:0]       csr_wdata;

   // Bars still owed by the block, oldest first.
   bar_result_type pending_bars[$];
   int          fault_count = 0;
   bit          hold_request = 1'b0;
   bit          steady_flow = 1'b0;

   // Predictor copy of the registers and of the clip traversal.
   logic [COUNT_W-1:0] reg_sample_count;
   logic [WIDTH_W-1:0] reg_full_width;
   logic [COUNT_W-1:0] seen_count;
   logic [BAR_W-1:0]   bar_now;
   logic [MAG_W-1:0]   peak_mag;
   logic [COUNT_W-1:0] sample_edge;
   logic [BAR_W-1:0]   sample_rem;
   logic [WIDTH_W-1:0] column_edge;
   logic [BAR_W-1:0]   column_rem;
   logic [WIDTH_W-1:0] column_start;

   // Directed table: reset geometry, extremes, zero width, short clip, clip end, restart.
   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      '{ROW_SAMPLE, CSR_SAMPLE_COUNT, 20'd0, 16'sd0,     1'b1, '{11'd0, 13'd0, 13'd1, 5'd1, 1'b0}},
      '{ROW_SAMPLE, CSR_SAMPLE_COUNT, 20'd0, 16'sd32767, 1'b1, '{11'd1, 13'd1, 13'd2, 5'd17, 1'b0}},
      '{ROW_SAMPLE, CSR_SAMPLE_COUNT, 20'd0, 16'sh8000,  1'b1, '{11'd2, 13'd2, 13'd3, 5'd18, 1'b0}},
      '{ROW_SAMPLE, CSR_SAMPLE_COUNT, 20'd0, -16'sd1,    1'b1, '{11'd3, 13'd3, 13'd4, 5'd1, 1'b0}},
      '{ROW_SAMPLE, CSR_SAMPLE_COUNT, 20'd0, 16'sd3641,  1'b1, '{11'd4, 13'd4, 13'd5, 5'd2, 1'b0}},
      '{ROW_WRITE,  CSR_FULL_WIDTH,   20'hFE000, 16'sd0, 1'b0, '0},
      '{ROW_WRITE,  CSR_SAMPLE_COUNT, 20'd0,     16'sd0, 1'b0, '0},
      '{ROW_SAMPLE, CSR_SAMPLE_COUNT, 20'd0, 16'sd12345, 1'b1, '{11'd0, 13'd0, 13'd1, 5'd6, 1'b1}},
      '{ROW_SAMPLE, CSR_SAMPLE_COUNT, 20'd0, -16'sd32767, 1'b1, '{11'd0, 13'd0, 13'd1, 5'd17, 1'b1}},
      '{ROW_SAMPLE, CSR_SAMPLE_COUNT, 20'd0, 16'sd0,     1'b1, '{11'd0, 13'd0, 13'd1, 5'd1, 1'b1}},
      '{ROW_WRITE,  CSR_FULL_WIDTH,   20'd5, 16'sd0, 1'b0, '0},
      '{ROW_WRITE,  CSR_SAMPLE_COUNT, 20'd7, 16'sd0, 1'b0, '0},
      '{ROW_SAMPLE, CSR_SAMPLE_COUNT, 20'd0, 16'sd100,    1'b0, '0},
      '{ROW_SAMPLE, CSR_SAMPLE_COUNT, 20'd0, -16'sd200,   1'b0, '0},
      '{ROW_SAMPLE, CSR_SAMPLE_COUNT, 20'd0, 16'sd30000,  1'b0, '0},
      '{ROW_SAMPLE, CSR_SAMPLE_COUNT, 20'd0, -16'sd5,     1'b0, '0},
      '{ROW_SAMPLE, CSR_SAMPLE_COUNT, 20'd0, 16'sd0,      1'b0, '0},
      '{ROW_SAMPLE, CSR_SAMPLE_COUNT, 20'd0, 16'sd20000,  1'b0, '0},
      '{ROW_SAMPLE, CSR_SAMPLE_COUNT, 20'd0, -16'sd20000, 1'b0, '0},
      '{ROW_SAMPLE, CSR_SAMPLE_COUNT, 20'd0, 16'sd7,      1'b0, '0},
      '{ROW_SAMPLE, CSR_SAMPLE_COUNT, 20'd0, 16'sd32767,  1'b0, '0},
      '{ROW_SAMPLE, CSR_SAMPLE_COUNT, 20'd0, -16'sd12000, 1'b0, '0},
      '{ROW_WRITE,  CSR_FULL_WIDTH,   20'd3, 16'sd0, 1'b0, '0},
      '{ROW_SAMPLE, CSR_SAMPLE_COUNT, 20'd0, 16'sd500,    1'b0, '0},
      '{ROW_SAMPLE, CSR_SAMPLE_COUNT, 20'd0, 16'sh8000,   1'b0, '0},
      '{ROW_SAMPLE, CSR_SAMPLE_COUNT, 20'd0, 16'sd16384,  1'b0, '0},
      '{ROW_SAMPLE, CSR_SAMPLE_COUNT, 20'd0, 16'sd1,      1'b0, '0}
   };

   waveform_peak_bar_decimator_unit u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_sample     (req_sample),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_bar_index  (rsp_bar_index),
      .rsp_x_start    (rsp_x_start),
      .rsp_x_end      (rsp_x_end),
      .rsp_bar_height (rsp_bar_height),
      .rsp_last_bar   (rsp_last_bar),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // A width of zero counts as one column.
   function automatic logic [WIDTH_W-1:0] column_width();
      return (reg_full_width == '0) ? 13'd1 : reg_full_width;
   endfunction

   function automatic logic [BARS_W-1:0] bar_total();
      logic [WIDTH_W-1:0] w;
      w = column_width();
      return (w < WIDTH_W'(MAX_BARS)) ? BARS_W'(w) : BARS_W'(MAX_BARS);
   endfunction

   // A clip shorter than the bar count is stretched to one sample per bar.
   function automatic logic [COUNT_W-1:0] clip_length();
      logic [BARS_W-1:0] b;
      b = bar_total();
      return (reg_sample_count < COUNT_W'(b)) ? COUNT_W'(b) : reg_sample_count;
   endfunction

   function automatic void restart_clip();
      logic [BARS_W-1:0]  b;
      logic [COUNT_W-1:0] n;
      logic [WIDTH_W-1:0] w;
      b = bar_total();
      n = clip_length();
      w = column_width();
      seen_count   = '0;
      bar_now      = '0;
      peak_mag     = '0;
      sample_edge  = n / b;
      sample_rem   = BAR_W'(n % b);
      column_edge  = WIDTH_W'(w / b);
      column_rem   = BAR_W'(w % b);
      column_start = '0;
   endfunction

   function automatic void apply_register(input logic [CSR_INDEX_W-1:0] idx,
                                          input logic [CSR_DATA_W-1:0] data);
      case (idx)
         CSR_SAMPLE_COUNT: reg_sample_count = data;
         CSR_FULL_WIDTH:   reg_full_width = data[WIDTH_W-1:0];
         default: ;
      endcase
      restart_clip();
   endfunction

   // Folds one sample into the running peak; returns 1 when it closes a bar.
   function automatic bit predict_bar(input logic signed [SAMPLE_W-1:0] s,
                                      output bar_result_type bar);
      logic [MAG_W-1:0]   mag;
      logic [BARS_W-1:0]  b;
      logic [COUNT_W-1:0] n;
      logic [WIDTH_W-1:0] w;
      logic [21:0]        scaled;
      logic [HEIGHT_W-1:0] h;
      logic [BARS_W-1:0]  rem_sum;
      bit                 at_end;
      bar = '0;
      b = bar_total();
      n = clip_length();
      w = column_width();
      mag = s[SAMPLE_W-1] ? (17'h10000 - {1'b0, s}) : {1'b0, s};
      if (mag > peak_mag) peak_mag = mag;
      seen_count = seen_count + COUNT_W'(1);
      if (seen_count != sample_edge) return 1'b0;

      scaled = 22'(peak_mag) * 22'(BAR_HALF_RANGE);
      h = HEIGHT_W'(scaled >> 15);
      if (h == '0) h = 5'd1;
      at_end = (BARS_W'(bar_now) + 12'd1) >= b;
      bar.bar_index  = bar_now;
      bar.x_start    = column_start;
      bar.x_end      = column_edge;
      bar.bar_height = h;
      bar.last_bar   = at_end;
      if (at_end) begin
         restart_clip();
         return 1'b1;
      end

      // Step both boundaries by quotient and carry the remainders.
      bar_now = bar_now + BAR_W'(1);
      peak_mag = '0;
      sample_edge = sample_edge + COUNT_W'(n / b);
      rem_sum = BARS_W'(sample_rem) + BARS_W'(n % b);
      if (rem_sum >= b) begin
         rem_sum = rem_sum - b;
         sample_edge = sample_edge + COUNT_W'(1);
      end
      sample_rem = rem_sum[BAR_W-1:0];
      column_start = column_edge;
      column_edge = column_edge + WIDTH_W'(w / b);
      rem_sum = BARS_W'(column_rem) + BARS_W'(w % b);
      if (rem_sum >= b) begin
         rem_sum = rem_sum - b;
         column_edge = column_edge + WIDTH_W'(1);
      end
      column_rem = rem_sum[BAR_W-1:0];
      return 1'b1;
   endfunction

   // Mostly extremes and quiet signal, with plenty of full-range noise.
   function automatic logic signed [SAMPLE_W-1:0] pick_sample();
      logic [SAMPLE_W-1:0] raw;
      case ($urandom_range(9))
         0: raw = 16'h8000;
         1: raw = 16'h7FFF;
         2: raw = 16'h0000;
         3: raw = $urandom_range(1) ? 16'h0001 : 16'hFFFF;
         4, 5: begin
            raw = 16'($urandom_range(0, 2000));
            if ($urandom_range(1)) raw = -raw;
         end
         default: raw = 16'($urandom());
      endcase
      return raw;
   endfunction

   // Offers one sample until its transfer completes, then updates the predictor.
   task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, output bit produced,
                              output bar_result_type bar);
      if (!steady_flow) begin
         while ($urandom_range(99) < IDLE_PERCENT) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_sample <= s;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      produced = predict_bar(s, bar);
   endtask

   // Lets every owed bar drain and the block settle before touching the registers.
   task automatic wait_for_idle();
      req_valid <= 1'b0;
      while (pending_bars.size() != 0) @(posedge clock);
      repeat (IDLE_PAUSE) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] data);
      wait_for_idle();
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      apply_register(idx, data);
   endtask

   // Result side: random back-pressure, one long hold on request, none in the steady stretch.
   initial begin : bar_sink
      int hold_left;
      hold_left = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
            rsp_ready <= 1'b0;
         end else if (steady_flow) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(99) >= IDLE_PERCENT);
         end
      end
   end

   // Each result transfer is matched against the oldest owed bar.
   always @(posedge clock) begin : bar_check
      bar_result_type want;
      bar_result_type got;
      bit          wrong;
      if (!reset && rsp_valid && rsp_ready) begin
         got.bar_index  = rsp_bar_index;
         got.x_start    = rsp_x_start;
         got.x_end      = rsp_x_end;
         got.bar_height = rsp_bar_height;
         got.last_bar   = rsp_last_bar;
         if (pending_bars.size() == 0) begin
            fault_count++;
            if (fault_count <= REPORT_LIMIT)
               $display("unexpected bar: idx %0d x %0d..%0d h %0d last %0d", got.bar_index,
                        got.x_start, got.x_end, got.bar_height, got.last_bar);
         end else begin
            want = pending_bars.pop_front();
            wrong = (got.bar_index !== want.bar_index) || (got.x_start !== want.x_start) ||
                    (got.x_end !== want.x_end) || (got.bar_height !== want.bar_height) ||
                    (got.last_bar !== want.last_bar);
            if (wrong) begin
               fault_count++;
               if (fault_count <= REPORT_LIMIT)
                  $display("bar mismatch: expected %0d/%0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d/%0d",
                           want.bar_index, want.x_start, want.x_end, want.bar_height,
                           want.last_bar, got.bar_index, got.x_start, got.x_end,
                           got.bar_height, got.last_bar);
            end
         end
      end
   end

   // Watchdog against a hung handshake.
   initial begin : watchdog
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("waveform_peak_bar_decimator_unit regression: fail");
      $finish;
   end

   initial begin : stimulus
      bit                   produced;
      bar_result_type       bar;
      int                   random_sent;
      int                   phase_items;
      int                   class_pick;
      int                   which;
      logic [WIDTH_W-1:0]   new_width;
      logic [COUNT_W-1:0]   new_count;

      reset <= 1'b1;
      req_valid <= 1'b0;
      req_sample <= '0;
      csr_we <= 1'b0;
      csr_index <= CSR_SAMPLE_COUNT;
      csr_wdata <= '0;
      reg_sample_count = COUNT_W'(RESET_SAMPLE_COUNT);
      reg_full_width = WIDTH_W'(RESET_FULL_WIDTH);
      restart_clip();
      random_sent = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed table; rows with a typed bar are checked against that bar.
      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         if (directed_rows[i].reg_kind == ROW_WRITE) begin
            write_register(directed_rows[i].reg_index, directed_rows[i].reg_data);
         end else begin
            send_sample(directed_rows[i].sample, produced, bar);
            if (directed_rows[i].typed) pending_bars.push_back(directed_rows[i].bar);
            else if (produced) pending_bars.push_back(bar);
         end
      end

      // One bar per sample while the result side holds off, so the block backs up.
      write_register(CSR_FULL_WIDTH, 20'd64);
      write_register(CSR_SAMPLE_COUNT, 20'd64);
      hold_request = 1'b1;
      repeat (150) begin
         send_sample(pick_sample(), produced, bar);
         if (produced) pending_bars.push_back(bar);
         random_sent++;
      end

      // Random clips: mostly short ones that end often, some wide, a few very long.
      while (random_sent < RANDOM_ITEMS) begin
         if ($urandom_range(99) < 20) begin
            phase_items = $urandom_range(20, 120);
         end else begin
            class_pick = $urandom_range(99);
            if (class_pick < 55) begin
               new_width = 13'($urandom_range(0, 48));
               new_count = 20'($urandom_range(0, 3 * (new_width + 1)));
               phase_items = $urandom_range(20, 120);
            end else if (class_pick < 75) begin
               new_width = ($urandom_range(3) == 0) ? 13'd8191
                                                    : 13'($urandom_range(2048, 8191));
               new_count = 20'($urandom_range(0, 4600));
               phase_items = $urandom_range(80, 250);
            end else if (class_pick < 90) begin
               new_width = 13'($urandom_range(49, 2047));
               new_count = 20'($urandom_range(0, 2 * new_width + 64));
               phase_items = $urandom_range(60, 200);
            end else begin
               new_width = 13'($urandom());
               new_count = $urandom_range(1) ? 20'hFFFFF : 20'($urandom());
               phase_items = $urandom_range(20, 60);
            end
            which = $urandom_range(3);
            if (which != 0) write_register(CSR_FULL_WIDTH, {7'($urandom()), new_width});
            if (which != 1) write_register(CSR_SAMPLE_COUNT, new_count);
         end
         for (int k = 0; k < phase_items && random_sent < RANDOM_ITEMS; k++) begin
            steady_flow = (random_sent >= 700) && (random_sent < 1000);
            send_sample(pick_sample(), produced, bar);
            if (produced) pending_bars.push_back(bar);
            random_sent++;
         end
      end
      steady_flow = 1'b0;

      wait_for_idle();
      if (fault_count == 0 && pending_bars.size() == 0) begin
         $display("waveform_peak_bar_decimator_unit regression: pass");
      end else begin
         $display("waveform_peak_bar_decimator_unit regression: fail");
      end
      $finish;
   end

endmodule
